>>> rtl/sops_pkg.sv
// shared types, constants and codes for the odd-only segmented prime sieve
package sops_pkg;

  // default sizing
  localparam int DEF_SEGMENT_BITS    = 64;
  localparam int DEF_MAX_BASE_PRIMES = 1024;

  // fixed field widths
  localparam int FLAG_W   = 64;
  localparam int ODD_W    = 33;
  localparam int SEG_W    = 27;
  localparam int LIMIT_W  = 32;
  localparam int PRIME_W  = 16;
  localparam int OFFSET_W = 2 * PRIME_W;

  // smallest prime the cells accept, all smaller ones are covered by the presieve
  localparam int FIRST_BASE_PRIME = 17;

  // presieve primes
  localparam int PRESIEVE_N = 5;
  localparam int PRESIEVE_PRIMES [PRESIEVE_N] = '{3, 5, 7, 11, 13};

  // segment zero fixups: 1 is not prime, 3 5 7 11 13 are
  localparam logic [FLAG_W-1:0] SEG0_SET   = 64'h0000_0000_0000_0001;
  localparam logic [FLAG_W-1:0] SEG0_CLEAR = 64'h0000_0000_0000_006E;

  // request kinds
  typedef enum logic [0:0] {
    REQ_LOAD  = 1'b0,
    REQ_SIEVE = 1'b1
  } req_kind_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_BEYOND = 2'd2
  } status_t;

  // token that walks down the cell chain, one per request
  typedef struct packed {
    logic              valid;
    logic              sieve;
    logic              seg_zero;
    status_t           status;
    logic [FLAG_W-1:0] composite;
    logic [ODD_W-1:0]  first_odd;
  } sops_token_t;

  // base prime write broadcast to the cells
  typedef struct packed {
    logic [PRIME_W-1:0]  prime;
    logic [OFFSET_W-1:0] offset;
  } load_wr_t;

endpackage

>>> rtl/sops_req_if.sv
// request channel: load or sieve transfer into the sieve
interface sops_req_if import sops_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [PRIME_W-1:0] base_prime;

  modport source (output valid, req_type, base_prime, input ready);
  modport sink   (input valid, req_type, base_prime, output ready);
endinterface

>>> rtl/sops_rsp_if.sv
// response channel: one result transfer per request
interface sops_rsp_if import sops_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [FLAG_W-1:0] prime_flags;
  logic [ODD_W-1:0]  first_odd;

  modport source (output valid, status, prime_flags, first_odd, input ready);
  modport sink   (input valid, status, prime_flags, first_odd, output ready);
endinterface

>>> rtl/sops_ring.sv
// rotating residue ring for one presieve prime, expanded to a segment mask
module sops_ring import sops_pkg::*; #(
  parameter int Q            = 3,
  parameter int SEGMENT_BITS = DEF_SEGMENT_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  output logic [SEGMENT_BITS-1:0] pattern
);

  localparam int HALF = (Q - 1) / 2;
  localparam int STEP = SEGMENT_BITS % Q;
  localparam logic [Q-1:0] RING_RESET = {{(Q-1){1'b0}}, 1'b1} << HALF;

  // ring bit x set when odd number of index phase+x is a multiple of q
  logic [Q-1:0] ring;
  logic [Q-1:0] ring_next;

  // rotate by the segment length mod q
  for (genvar x = 0; x < Q; x++) begin : g_rot
    assign ring_next[x] = ring[(x + STEP) % Q];
  end

  // repeat the ring across the segment
  for (genvar i = 0; i < SEGMENT_BITS; i++) begin : g_pat
    assign pattern[i] = ring[i % Q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring <= RING_RESET;
    end else if (advance) begin
      ring <= ring_next;
    end
  end

endmodule

>>> rtl/sops_cell.sv
// one base prime cell: marks its multiples into the passing segment token
module sops_cell import sops_pkg::*; #(
  parameter int SEGMENT_BITS = DEF_SEGMENT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        active,
  input  logic        wr_sel,
  input  load_wr_t    wr,
  input  sops_token_t tok_in,
  output sops_token_t tok_out
);

  localparam int J_W   = $clog2(SEGMENT_BITS);
  localparam int MARKS = (SEGMENT_BITS + FIRST_BASE_PRIME - 1) / FIRST_BASE_PRIME;
  localparam int T_W   = PRIME_W + $clog2(MARKS + 1) + 1;

  logic [PRIME_W-1:0]      prime;
  logic [OFFSET_W-1:0]     offset;
  logic [OFFSET_W-1:0]     offset_next;
  logic [SEGMENT_BITS-1:0] mark;
  sops_token_t             tok_next;

  // marks within this segment and the offset into the next one
  always_comb begin
    logic [T_W-1:0]      t [0:MARKS];
    logic                near;
    logic                found;
    logic [OFFSET_W-1:0] step_next;
    near      = offset < OFFSET_W'(SEGMENT_BITS);
    t[0]      = T_W'(offset[J_W-1:0]);
    for (int k = 1; k <= MARKS; k++) begin
      t[k] = t[k-1] + T_W'(prime);
    end
    mark = '0;
    for (int k = 0; k < MARKS; k++) begin
      if (near && (t[k] < T_W'(SEGMENT_BITS))) begin
        mark[t[k][J_W-1:0]] = 1'b1;
      end
    end
    found     = 1'b0;
    step_next = '0;
    for (int k = 0; k <= MARKS; k++) begin
      if (!found && (t[k] >= T_W'(SEGMENT_BITS))) begin
        step_next = OFFSET_W'(t[k] - T_W'(SEGMENT_BITS));
        found     = 1'b1;
      end
    end
    offset_next = near ? step_next : offset - OFFSET_W'(SEGMENT_BITS);
  end

  // merge marks into the token
  always_comb begin
    tok_next = tok_in;
    if (tok_in.sieve && active) begin
      tok_next.composite = tok_in.composite | FLAG_W'(mark);
    end
  end

  // prime and offset store
  always_ff @(posedge clk) begin
    if (wr_sel) begin
      prime  <= wr.prime;
      offset <= wr.offset;
    end else if (en && tok_in.valid && tok_in.sieve && active) begin
      offset <= offset_next;
    end
  end

  // hand the token on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok_out <= tok_next;
    end
  end

endmodule

>>> rtl/segmented_odd_prime_sieve_core.sv
// top level of the odd-only segmented prime sieve with presieve and cell chain
//
//  channel   dir   handshake       payload
//  req       in    valid/ready     req_type, base_prime
//  rsp       out   valid/ready     status, prime_flags, first_odd
//  cfg       in    cfg_we          cfg_wdata (sieve_limit)
//
// one request is taken per cycle while the chain is not held; its result leaves
// once the token has passed the register of every cell of the base prime chain
// synchronous active-high reset clears counters, presieve phase and tokens
// prime and offset cells hold no reset value until a load writes them
// while a result waits untaken the whole chain holds and req.ready is low
module segmented_odd_prime_sieve_core import sops_pkg::*; #(
  parameter int SEGMENT_BITS    = DEF_SEGMENT_BITS,
  parameter int MAX_BASE_PRIMES = DEF_MAX_BASE_PRIMES
) (
  input  logic               clk,
  input  logic               rst,
  sops_req_if.sink           req,
  sops_rsp_if.source         rsp,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  localparam int CNT_W  = $clog2(MAX_BASE_PRIMES + 1);
  localparam int BASE_W = SEG_W + $clog2(SEGMENT_BITS + 1);
  localparam int LO_W   = BASE_W + 2;
  localparam logic [FLAG_W-1:0] ALL_MASK = {FLAG_W{1'b1}} >> (FLAG_W - SEGMENT_BITS);

  logic [LIMIT_W-1:0]      sieve_limit;
  logic [CNT_W-1:0]        loaded_count;
  logic [SEG_W-1:0]        seg_num;
  logic [BASE_W-1:0]       base_idx;
  logic                    started;

  logic                    en;
  logic                    fire;
  logic                    is_sieve;
  logic                    load_ok;
  logic                    load_fire;
  logic                    sieve_fire;
  logic [LO_W-1:0]         lo;
  logic [LO_W-1:0]         last;
  logic                    beyond;
  logic [OFFSET_W-1:0]     sq;
  load_wr_t                wr_data;
  logic [SEGMENT_BITS-1:0] ring_pat [PRESIEVE_N];
  logic [SEGMENT_BITS-1:0] presieve;
  sops_token_t             tok [0:MAX_BASE_PRIMES];
  sops_token_t             tail;
  logic [FLAG_W-1:0]       fixed;

  // handshake: the chain moves unless a result waits untaken
  assign en        = !tail.valid || rsp.ready;
  assign req.ready = en;
  assign fire      = req.valid && en;

  // request decode
  assign is_sieve   = (req.req_type == REQ_SIEVE);
  assign load_ok    = !started && (loaded_count < CNT_W'(MAX_BASE_PRIMES)) &&
                      (req.base_prime >= PRIME_W'(FIRST_BASE_PRIME)) && req.base_prime[0];
  assign load_fire  = fire && !is_sieve && load_ok;
  assign sieve_fire = fire && is_sieve;

  // segment range and limit check
  assign lo     = {1'b0, base_idx, 1'b1};
  assign last   = lo + LO_W'(2 * (SEGMENT_BITS - 1));
  assign beyond = last > LO_W'(sieve_limit);

  // first offset of a new base prime: index of p*p
  assign sq             = {{PRIME_W{1'b0}}, req.base_prime} * {{PRIME_W{1'b0}}, req.base_prime};
  assign wr_data.prime  = req.base_prime;
  assign wr_data.offset = (sq - OFFSET_W'(1)) >> 1;

  // presieve rings for 3, 5, 7, 11 and 13
  for (genvar q = 0; q < PRESIEVE_N; q++) begin : g_ring
    sops_ring #(
      .Q            (PRESIEVE_PRIMES[q]),
      .SEGMENT_BITS (SEGMENT_BITS)
    ) u_ring (
      .clk     (clk),
      .rst     (rst),
      .advance (sieve_fire),
      .pattern (ring_pat[q])
    );
  end

  always_comb begin
    presieve = '0;
    for (int q = 0; q < PRESIEVE_N; q++) begin
      presieve = presieve | ring_pat[q];
    end
  end

  // token at the head of the chain
  always_comb begin
    tok[0].valid     = fire;
    tok[0].sieve     = is_sieve;
    tok[0].seg_zero  = is_sieve && (seg_num == '0);
    tok[0].composite = is_sieve ? FLAG_W'(presieve) : '0;
    tok[0].first_odd = is_sieve ? lo[ODD_W-1:0] : '0;
    if (is_sieve) begin
      tok[0].status = beyond ? STATUS_BEYOND : STATUS_OK;
    end else begin
      tok[0].status = load_ok ? STATUS_OK : STATUS_REJECT;
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      sieve_limit  <= {LIMIT_W{1'b1}};
      loaded_count <= '0;
      seg_num      <= '0;
      base_idx     <= '0;
      started      <= 1'b0;
    end else begin
      if (cfg_we) begin
        sieve_limit <= cfg_wdata;
      end
      if (load_fire) begin
        loaded_count <= loaded_count + CNT_W'(1);
      end
      if (sieve_fire) begin
        started  <= 1'b1;
        seg_num  <= seg_num + SEG_W'(1);
        base_idx <= (seg_num == {SEG_W{1'b1}}) ? '0 : base_idx + BASE_W'(SEGMENT_BITS);
      end
    end
  end

  // base prime cell chain
  for (genvar k = 0; k < MAX_BASE_PRIMES; k++) begin : g_cell
    logic active;
    logic wr_sel;
    assign active = CNT_W'(k) < loaded_count;
    assign wr_sel = load_fire && (loaded_count == CNT_W'(k));

    sops_cell #(
      .SEGMENT_BITS (SEGMENT_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .active  (active),
      .wr_sel  (wr_sel),
      .wr      (wr_data),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  // result: segment zero fixups and inversion to prime flags
  assign tail  = tok[MAX_BASE_PRIMES];
  assign fixed = tail.seg_zero ? ((tail.composite | SEG0_SET) & ~SEG0_CLEAR) : tail.composite;

  assign rsp.valid       = tail.valid;
  assign rsp.status      = tail.status;
  assign rsp.prime_flags = tail.sieve ? (ALL_MASK & ~fixed) : '0;
  assign rsp.first_odd   = tail.first_odd;

endmodule

>>> rtl/sops_checker.sv
// port-level checks for the sieve core and their bind to the top level
module sops_checker import sops_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [1:0]        rsp_status,
  input logic [FLAG_W-1:0] rsp_prime_flags,
  input logic [ODD_W-1:0]  rsp_first_odd
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_prime_flags) && $stable(rsp_first_odd))
    else $error("stalled result changed");

  // no new transfer is taken while the result is stalled
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while result stalled");

  // reset empties the chain
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // rejected loads carry no bitmap and no segment start
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STATUS_REJECT) |->
      (rsp_prime_flags == '0) && (rsp_first_odd == '0))
    else $error("rejected load with payload");

  // limit flag only on segments, whose start is odd
  a_beyond_odd: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STATUS_BEYOND) |-> rsp_first_odd[0])
    else $error("limit flag on a non-segment result");

endmodule

bind segmented_odd_prime_sieve_core sops_checker u_sops_checker (
  .clk             (clk),
  .rst             (rst),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_prime_flags (rsp.prime_flags),
  .rsp_first_odd   (rsp.first_odd)
);

>>> verif/segmented_odd_prime_sieve_core_tb.sv
// self-checking testbench for the odd-only segmented prime sieve core
`timescale 1ns / 1ps

module segmented_odd_prime_sieve_core_tb;
  import sops_pkg::*;

  localparam int SEG_BITS        = DEF_SEGMENT_BITS;
  localparam int MAX_PRIMES      = DEF_MAX_BASE_PRIMES;
  localparam int WHEEL_PERIOD    = 15015;
  localparam int STALL_LIMIT     = 8 * (MAX_PRIMES + 200);
  localparam logic [FLAG_W-1:0] SMALL_PRIME_BITS = 64'h0000_0000_0000_006E;

  // expected result of one request
  typedef struct packed {
    status_t           status;
    logic [FLAG_W-1:0] flags;
    logic [ODD_W-1:0]  first;
  } seg_result_t;

  // directed stimulus row, loads carry a hand-written status
  typedef struct packed {
    req_kind_t          kind;
    logic [PRIME_W-1:0] prime;
    logic               typed;
    status_t            status;
  } script_row_t;

  localparam int LOAD_ROWS   = 9;
  localparam int SCRIPT_ROWS = 17;
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    // unfit primes: zero, one, odd below 17, even values
    '{REQ_LOAD,  16'd0,     1'b1, STATUS_REJECT},
    '{REQ_LOAD,  16'd1,     1'b1, STATUS_REJECT},
    '{REQ_LOAD,  16'd15,    1'b1, STATUS_REJECT},
    '{REQ_LOAD,  16'd16,    1'b1, STATUS_REJECT},
    '{REQ_LOAD,  16'd18,    1'b1, STATUS_REJECT},
    '{REQ_LOAD,  16'hFFFE,  1'b1, STATUS_REJECT},
    // first base primes
    '{REQ_LOAD,  16'd17,    1'b1, STATUS_OK},
    '{REQ_LOAD,  16'd19,    1'b1, STATUS_OK},
    '{REQ_LOAD,  16'd23,    1'b1, STATUS_OK},
    // segment zero, then late loads mixed with sieves
    '{REQ_SIEVE, 16'd0,     1'b0, STATUS_OK},
    '{REQ_SIEVE, 16'hFFFF,  1'b0, STATUS_OK},
    '{REQ_LOAD,  16'd17,    1'b1, STATUS_REJECT},
    '{REQ_LOAD,  16'hFFFF,  1'b1, STATUS_REJECT},
    '{REQ_SIEVE, 16'd0,     1'b0, STATUS_OK},
    '{REQ_SIEVE, 16'd0,     1'b0, STATUS_OK},
    '{REQ_LOAD,  16'd29,    1'b1, STATUS_REJECT},
    '{REQ_SIEVE, 16'd0,     1'b0, STATUS_OK}
  };

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  sops_req_if req ();
  sops_rsp_if rsp ();

  segmented_odd_prime_sieve_core #(
    .SEGMENT_BITS    (SEG_BITS),
    .MAX_BASE_PRIMES (MAX_PRIMES)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow state of the sieve
  logic [PRIME_W-1:0]  loaded_primes [MAX_PRIMES];
  logic [OFFSET_W-1:0] mark_offset   [MAX_PRIMES];
  int unsigned         n_loaded;
  logic [SEG_W-1:0]    seg_num;
  logic [13:0]         wheel_phase;
  bit                  sieve_begun;
  logic [LIMIT_W-1:0]  limit_shadow;

  seg_result_t awaited[$];
  int unsigned error_count;
  bit          steady_tx;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length, mostly short with the odd long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic bit is_prime(input int v);
    int d;
    for (d = 3; d * d <= v; d += 2)
      if (v % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  // apply one request to the shadow state and return its result
  function automatic seg_result_t sieve_advance(input req_kind_t kind,
                                                input logic [PRIME_W-1:0] prime);
    seg_result_t        res;
    logic [FLAG_W-1:0]  composite;
    logic [63:0]        j;
    logic [63:0]        lo;
    logic [31:0]        sq;
    int                 n;
    int                 i;
    int unsigned        t;
    res = '{STATUS_OK, '0, '0};
    if (kind == REQ_LOAD) begin
      if (sieve_begun || n_loaded >= MAX_PRIMES ||
          prime < 16'(FIRST_BASE_PRIME) || !prime[0]) begin
        res.status = STATUS_REJECT;
      end else begin
        sq = 32'(prime) * 32'(prime);
        loaded_primes[n_loaded] = prime;
        mark_offset[n_loaded]   = (sq - 32'd1) >> 1;
        n_loaded++;
      end
      return res;
    end
    sieve_begun = 1'b1;
    // presieve wheel for 3 5 7 11 13
    composite = '0;
    for (i = 0; i < SEG_BITS; i++) begin
      n = 2 * (int'(wheel_phase) + i) + 1;
      if (n % 3 == 0 || n % 5 == 0 || n % 7 == 0 || n % 11 == 0 || n % 13 == 0)
        composite[i] = 1'b1;
    end
    // each base prime marks from its offset, then rebases
    for (t = 0; t < n_loaded; t++) begin
      j = 64'(mark_offset[t]);
      while (j < SEG_BITS) begin
        composite[j[5:0]] = 1'b1;
        j += 64'(loaded_primes[t]);
      end
      mark_offset[t] = 32'(j - SEG_BITS);
    end
    // segment zero: 1 is composite, the presieve primes are prime
    if (seg_num == '0) begin
      composite[0] = 1'b1;
      composite &= ~SMALL_PRIME_BITS;
    end
    lo = 64'(seg_num) * (2 * SEG_BITS) + 64'd1;
    res.status = (lo + 2 * (SEG_BITS - 1) > 64'(limit_shadow)) ? STATUS_BEYOND : STATUS_OK;
    res.first  = lo[ODD_W-1:0];
    res.flags  = ~composite;
    seg_num     = seg_num + 1'b1;
    wheel_phase = 14'((int'(wheel_phase) + SEG_BITS) % WHEEL_PERIOD);
    return res;
  endfunction

  // one request transfer, with a random lead-in gap
  task automatic send_req(input req_kind_t kind, input logic [PRIME_W-1:0] prime,
                          input logic typed, input status_t typed_status);
    int          gap;
    seg_result_t want;
    if ($urandom_range(0, 49) == 0) steady_tx = !steady_tx;
    gap = steady_tx ? 0 : idle_len();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.req_type   <= kind;
    req.base_prime <= prime;
    do @(posedge clk); while (req.ready !== 1'b1);
    want = sieve_advance(kind, prime);
    if (typed) want = '{typed_status, '0, '0};
    awaited.push_back(want);
  endtask

  // drain, then write the sieve limit while the core is idle
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    req.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    limit_shadow  = value;
  endtask

  // result sink with random stalls
  initial begin : result_sink
    int run;
    int gap;
    rsp.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      rsp.ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = idle_len();
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    seg_result_t want;
    if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result status %0d flags %h first_odd %h",
                 $time, rsp.status, rsp.prime_flags, rsp.first_odd);
        error_count++;
      end else begin
        want = awaited.pop_front();
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
          error_count++;
        end
        if (rsp.prime_flags !== want.flags) begin
          $display("%0t: prime_flags expected %h actual %h",
                   $time, want.flags, rsp.prime_flags);
          error_count++;
        end
        if (rsp.first_odd !== want.first) begin
          $display("%0t: first_odd expected %h actual %h", $time, want.first, rsp.first_odd);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    do begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
      else quiet++;
    end while (quiet < STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int                 i;
    int                 p;
    int                 ph;
    int                 k;
    logic [LIMIT_W-1:0] lim;
    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.req_type   <= REQ_LOAD;
    req.base_prime <= '0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    n_loaded     = 0;
    seg_num      = '0;
    wheel_phase  = '0;
    sieve_begun  = 1'b0;
    limit_shadow = '1;
    error_count  = 0;
    steady_tx    = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_limit(32'hFFFF_FFFF);

    // directed loads
    for (i = 0; i < LOAD_ROWS; i++)
      send_req(SCRIPT[i].kind, SCRIPT[i].prime, SCRIPT[i].typed, SCRIPT[i].status);

    // fill the table with ascending primes, some unfit values mixed in
    p = 29;
    while (n_loaded < MAX_PRIMES - 3) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0)
          send_req(REQ_LOAD, 16'($urandom_range(0, 65535)) & 16'hFFFE, 1'b0, STATUS_OK);
        else
          send_req(REQ_LOAD, 16'($urandom_range(0, 16)), 1'b0, STATUS_OK);
      end else begin
        while (!is_prime(p)) p += 2;
        send_req(REQ_LOAD, 16'(p), 1'b0, STATUS_OK);
        p += 2;
      end
    end
    // large odd values take the last entries, then the table is full
    while (n_loaded < MAX_PRIMES)
      send_req(REQ_LOAD, 16'h8001 | 16'($urandom_range(0, 32767)), 1'b0, STATUS_OK);
    repeat (6)
      send_req(REQ_LOAD, 16'($urandom_range(17, 65535)) | 16'h0001, 1'b0, STATUS_OK);

    // directed sieves and late loads
    for (i = LOAD_ROWS; i < SCRIPT_ROWS; i++)
      send_req(SCRIPT[i].kind, SCRIPT[i].prime, SCRIPT[i].typed, SCRIPT[i].status);

    // random sieving under several limits
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: lim = 32'd1;
        1: lim = 32'(seg_num) * 32'(2 * SEG_BITS) + 32'd1 +
                 32'(2 * SEG_BITS * $urandom_range(20, 80)) + 32'($urandom_range(0, 127));
        2: lim = $urandom();
        default: lim = 32'hFFFF_FFFF;
      endcase
      write_limit(lim);
      for (k = 0; k < 100; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_req(REQ_LOAD, 16'($urandom_range(0, 65535)), 1'b0, STATUS_OK);
        else
          send_req(REQ_SIEVE, 16'($urandom_range(0, 65535)), 1'b0, STATUS_OK);
      end
    end

    // drain and let any stray result show up
    req.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (MAX_PRIMES + 32) @(posedge clk);
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
